### rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket shaper package
// Shared widths, reset values, result status codes and controller state codes.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // Field widths that the interface fixes.
    localparam int unsigned TAG_W   = 16;
    localparam int unsigned TOKEN_W = 16;
    localparam int unsigned ENTRY_W = TAG_W + TOKEN_W;

    // Default queue depth and the bucket depth loaded at reset.
    localparam int unsigned           QUEUE_DEPTH_DEF  = 64;
    localparam logic [TOKEN_W-1:0]    BUCKET_DEPTH_RST = 16'd10;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_QUEUED     = 3'd0,
        ST_DROP_NEED  = 3'd1,
        ST_DROP_FULL  = 3'd2,
        ST_TOKEN_ADD  = 3'd3,
        ST_TOKEN_DROP = 3'd4
    } t_status;

    // Event kinds carried by the func field.
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

### rtl/tbs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/token_bucket_shaper.sv
// ----------------------------------------------------------------------------
// Token bucket shaper
// Packet arrivals and token ticks drive a token bucket and a bounded packet FIFO.
// ----------------------------------------------------------------------------
// Each input beat is a packet arrival or a token tick and produces exactly one
// result beat. In the accept cycle the head entry of the waiting queue is read
// from the queue RAM, and in the next cycle the bucket and queue are updated, an
// arrival that must wait is written at the tail and the result is loaded into
// the output register. A new item is accepted only when the previous one has
// been executed and the output register is free or being emptied. A pending
// result in the output register does not block the next item from being
// accepted in the same cycle that result is taken.
// The bucket depth register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module token_bucket_shaper #(
    parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbs_pkg::TOKEN_W-1:0]          i_cfg_data,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic [tbs_pkg::TAG_W-1:0]            i_packet_tag,
    input  logic [tbs_pkg::TOKEN_W-1:0]          i_tokens_needed,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_status,
    output logic                                 o_released,
    output logic [tbs_pkg::TAG_W-1:0]            o_released_tag,
    output logic [tbs_pkg::TOKEN_W-1:0]          o_tokens_left,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_queue_count
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TAG_W = tbs_pkg::TAG_W;
    localparam int unsigned TOK_W = tbs_pkg::TOKEN_W;

    // Controller and bucket state.
    tbs_pkg::t_state    r_state, n_state;
    logic [TOK_W-1:0]   r_bucket_depth;
    logic [TOK_W-1:0]   r_level, n_level;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;

    // Captured input beat.
    logic               r_func;
    logic [TAG_W-1:0]   r_tag;
    logic [TOK_W-1:0]   r_need;

    // Output register.
    logic               r_out_valid, n_out_valid;
    tbs_pkg::t_status   r_status, n_status;
    logic               r_released, n_released;
    logic [TAG_W-1:0]   r_rel_tag, n_rel_tag;

    // Queue RAM signals.
    logic                        w_push;
    logic [tbs_pkg::ENTRY_W-1:0] w_head_entry;
    logic [TOK_W-1:0]            w_head_need;
    logic [TAG_W-1:0]            w_head_tag;
    logic [TOK_W-1:0]            w_tick_level;
    logic                        w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Accept when idle and the output register is free by the next edge.
    assign o_in_ready = (r_state == tbs_pkg::S_IDLE) && (!r_out_valid || i_out_ready);

    // Queue storage: entry holds the tag above the need.
    tbs_ram #(
        .WIDTH (tbs_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_tail),
        .i_wdata ({r_tag, r_need}),
        .i_raddr (r_head),
        .o_rdata (w_head_entry)
    );

    assign w_head_need = w_head_entry[TOK_W-1:0];
    assign w_head_tag  = w_head_entry[tbs_pkg::ENTRY_W-1:TOK_W];

    // Bucket level after a tick has offered its token.
    assign w_tick_level = (r_level < r_bucket_depth) ? r_level + 1'b1 : r_level;

    // Event processing in the execute cycle.
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_released  = r_released;
        n_rel_tag   = r_rel_tag;
        w_push      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tbs_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = tbs_pkg::S_EXEC;
                end
            end
            tbs_pkg::S_EXEC: begin
                n_state     = tbs_pkg::S_IDLE;
                n_out_valid = 1'b1;
                n_released  = 1'b0;
                n_rel_tag   = '0;
                if (r_func == tbs_pkg::FUNC_ARRIVAL) begin
                    if (r_need > r_bucket_depth) begin
                        n_status = tbs_pkg::ST_DROP_NEED;
                    end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        n_status = tbs_pkg::ST_DROP_FULL;
                    end else begin
                        n_status = tbs_pkg::ST_QUEUED;
                        if ((r_count == '0) && (r_level >= r_need)) begin
                            // Empty queue and enough tokens: the packet passes at once.
                            n_level    = r_level - r_need;
                            n_released = 1'b1;
                            n_rel_tag  = r_tag;
                        end else begin
                            w_push  = 1'b1;
                            n_tail  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end else begin
                    n_status = (r_level < r_bucket_depth) ?
                               tbs_pkg::ST_TOKEN_ADD : tbs_pkg::ST_TOKEN_DROP;
                    n_level  = w_tick_level;
                    // Release the head packet if the bucket now covers it.
                    if ((r_count != '0) && (w_tick_level >= w_head_need)) begin
                        n_level    = w_tick_level - w_head_need;
                        n_released = 1'b1;
                        n_rel_tag  = w_head_tag;
                        n_head     = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : r_head + 1'b1;
                        n_count    = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_state = tbs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tbs_pkg::S_IDLE;
            r_bucket_depth <= tbs_pkg::BUCKET_DEPTH_RST;
            r_level        <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket_depth <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_func;
            r_tag  <= i_packet_tag;
            r_need <= i_tokens_needed;
        end
        r_status   <= n_status;
        r_released <= n_released;
        r_rel_tag  <= n_rel_tag;
    end

    // Output channel.
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_released     = r_released;
    assign o_released_tag = r_rel_tag;
    assign o_tokens_left  = r_level;
    assign o_queue_count  = r_count;

`ifndef NO_ASSERTIONS
    // The queue never holds more packets than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds queue depth");

    // An accepted beat is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == tbs_pkg::S_EXEC))
        else $error("accepted beat not executed");

    // Execution always loads a result into the output register.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbs_pkg::S_EXEC) |=> o_out_valid)
        else $error("execution produced no result");

    // A result without a release carries a zero tag.
    a_rel_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_released) |-> (o_released_tag == '0))
        else $error("released tag set without a release");
`endif

endmodule
